@@ sv/rnbd_pkg.sv @@
package rnbd_pkg;

  localparam int LENGTH_BITS_DEFAULT = 32;
  localparam int QUEUE_DEPTH_DEFAULT = 4;
  localparam int MAX_RESULTS         = 4;

  localparam logic [3:0] HDR_LEN = 4'd9;

  localparam logic [7:0] CHAR_CR   = 8'h0D;
  localparam logic [7:0] CHAR_LF   = 8'h0A;
  localparam logic [7:0] CHAR_NUL  = 8'h00;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_HASH = 8'h23;

  localparam logic [31:0] MAX_LEN_RESET = 32'hFFFF_FFFF;

  localparam logic [1:0] KIND_BYTE    = 2'd0;
  localparam logic [1:0] KIND_END     = 2'd1;
  localparam logic [1:0] KIND_DONE    = 2'd2;
  localparam logic [1:0] KIND_CORRUPT = 2'd3;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_LENGTH,
    PH_BODY,
    PH_CORRUPT
  } phase_t;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       end_of_file;
  } item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [31:0] error_offset;
    logic        last;
  } result_t;

  // one result without the last flag; the back end derives it
  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_out;
    logic [31:0] error_offset;
  } entry_t;

  // all results caused by one input byte
  typedef struct packed {
    logic [2:0]               count;
    entry_t [MAX_RESULTS-1:0] entry;
  } batch_t;

  // "#! rnews "
  function automatic logic [7:0] hdr_char(input logic [3:0] idx);
    logic [7:0] ch;
    unique case (idx)
      4'd0:    ch = CHAR_HASH;
      4'd1:    ch = 8'h21;
      4'd2:    ch = 8'h20;
      4'd3:    ch = 8'h72;
      4'd4:    ch = 8'h6E;
      4'd5:    ch = 8'h65;
      4'd6:    ch = 8'h77;
      4'd7:    ch = 8'h73;
      4'd8:    ch = 8'h20;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

@@ sv/rnbd_queue.sv @@
module rnbd_queue #(
  parameter int DEPTH = rnbd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_en,
  input  rnbd_pkg::batch_t wr_data,
  output logic            full,
  input  logic            rd_en,
  output rnbd_pkg::batch_t rd_data,
  output logic            empty
);
  import rnbd_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  batch_t           slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] fill;

  logic do_wr;
  logic do_rd;

  assign full    = (fill == CNT_FULL);
  assign empty   = (fill == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CNT_W'(1);
      end
    end
  end

endmodule

@@ sv/rnbd_front.sv @@
module rnbd_front #(
  parameter int LENGTH_BITS = rnbd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  rnbd_pkg::item_t  item,
  input  logic             cfg_write,
  input  logic [31:0]      cfg_data,
  output logic             batch_valid,
  output rnbd_pkg::batch_t batch
);
  import rnbd_pkg::*;

  localparam int LBW   = LENGTH_BITS + 4;
  localparam int CMP_W = (LBW > 32) ? LBW : 32;

  phase_t                 phase, phase_next;
  logic [3:0]             hidx, hidx_next;
  logic [LENGTH_BITS-1:0] acc, acc_next;
  logic [LENGTH_BITS-1:0] rem, rem_next;
  logic                   held, held_next;
  logic                   ended, ended_next;
  logic [31:0]            offset, offset_next;
  logic [31:0]            max_len;

  logic [7:0]  c;
  logic        eof;
  logic [31:0] past;
  logic [LBW-1:0] len_val;
  logic        too_big;
  logic        is_digit;

  logic        e_cr1, e_byte, e_cr2, e_end, e_cor, e_fin;
  logic        held_b;
  logic [31:0] cor_off;
  logic [2:0]  n;

  assign c    = item.byte_in;
  assign eof  = item.end_of_file;
  assign past = offset + 32'd1;

  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign len_val  = LBW'({acc, 3'b000}) + LBW'({acc, 1'b0}) + LBW'(c[3:0]);
  assign too_big  = (|len_val[LBW-1:LENGTH_BITS]) || (CMP_W'(len_val) > CMP_W'(max_len));

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= MAX_LEN_RESET;
    end else if (cfg_write) begin
      max_len <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEADER;
      hidx   <= '0;
      acc    <= '0;
      rem    <= '0;
      held   <= 1'b0;
      ended  <= 1'b0;
      offset <= '0;
    end else begin
      phase  <= phase_next;
      hidx   <= hidx_next;
      acc    <= acc_next;
      rem    <= rem_next;
      held   <= held_next;
      ended  <= ended_next;
      offset <= offset_next;
    end
  end

  always_comb begin
    phase_next  = phase;
    hidx_next   = hidx;
    acc_next    = acc;
    rem_next    = rem;
    held_next   = held;
    ended_next  = ended;
    offset_next = offset;
    e_cr1   = 1'b0;
    e_byte  = 1'b0;
    e_cr2   = 1'b0;
    e_end   = 1'b0;
    e_cor   = 1'b0;
    e_fin   = 1'b0;
    held_b  = held;
    cor_off = '0;
    n       = '0;
    batch   = '0;

    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          // mismatch and truncated header both point at the header start
          if (hidx < HDR_LEN && c == hdr_char(hidx)) begin
            hidx_next = hidx + 4'd1;
            if (hidx_next >= HDR_LEN) begin
              phase_next = PH_LENGTH;
              acc_next   = '0;
              if (eof) begin
                e_cor   = 1'b1;
                cor_off = past;
              end
            end else if (eof) begin
              e_cor   = 1'b1;
              cor_off = offset - 32'(hidx);
            end
          end else begin
            e_cor   = 1'b1;
            cor_off = offset - 32'(hidx);
          end
        end
        PH_LENGTH: begin
          if (is_digit) begin
            if (too_big) begin
              e_cor   = 1'b1;
              cor_off = offset;
            end else begin
              acc_next = len_val[LENGTH_BITS-1:0];
              if (eof) begin
                e_cor   = 1'b1;
                cor_off = past;
              end
            end
          end else if (c == CHAR_LF) begin
            rem_next   = acc;
            held_next  = 1'b0;
            ended_next = 1'b0;
            if (acc == '0) begin
              e_end      = 1'b1;
              phase_next = PH_HEADER;
              hidx_next  = '0;
              e_fin      = eof;
            end else begin
              phase_next = PH_BODY;
              if (eof) begin
                e_cor   = 1'b1;
                cor_off = past;
              end
            end
          end else begin
            e_cor   = 1'b1;
            cor_off = offset;
          end
        end
        PH_BODY: begin
          if (!ended) begin
            if (c == CHAR_NUL) begin
              e_cr1      = held;
              held_b     = 1'b0;
              ended_next = 1'b1;
            end else if (c == CHAR_CR) begin
              e_cr1  = held;
              held_b = 1'b1;
            end else begin
              e_cr1  = held && (c != CHAR_LF);
              held_b = 1'b0;
              e_byte = 1'b1;
            end
          end
          rem_next = (rem == '0) ? '0 : rem - LENGTH_BITS'(1);
          if (rem_next == '0) begin
            e_cr2      = held_b;
            held_next  = 1'b0;
            e_end      = 1'b1;
            phase_next = PH_HEADER;
            hidx_next  = '0;
            e_fin      = eof;
          end else begin
            held_next = held_b;
            if (eof) begin
              e_cor   = 1'b1;
              cor_off = past;
            end
          end
        end
        PH_CORRUPT: begin
        end
        default: begin
          phase_next = PH_CORRUPT;
        end
      endcase

      if (e_cor) begin
        phase_next = PH_CORRUPT;
        held_next  = 1'b0;
      end

      offset_next = past;
      if (eof) begin
        phase_next  = PH_HEADER;
        hidx_next   = '0;
        acc_next    = '0;
        rem_next    = '0;
        held_next   = 1'b0;
        ended_next  = 1'b0;
        offset_next = '0;
      end

      // results in the order the framing produces them
      if (e_cr1) begin
        batch.entry[n[1:0]] = '{kind: KIND_BYTE, byte_out: CHAR_CR, error_offset: '0};
        n = n + 3'd1;
      end
      if (e_byte) begin
        batch.entry[n[1:0]] = '{kind: KIND_BYTE, byte_out: c, error_offset: '0};
        n = n + 3'd1;
      end
      if (e_cr2) begin
        batch.entry[n[1:0]] = '{kind: KIND_BYTE, byte_out: CHAR_CR, error_offset: '0};
        n = n + 3'd1;
      end
      if (e_end) begin
        batch.entry[n[1:0]] = '{kind: KIND_END, byte_out: '0, error_offset: '0};
        n = n + 3'd1;
      end
      if (e_cor) begin
        batch.entry[n[1:0]] = '{kind: KIND_CORRUPT, byte_out: '0, error_offset: cor_off};
        n = n + 3'd1;
      end
      if (e_fin) begin
        batch.entry[n[1:0]] = '{kind: KIND_DONE, byte_out: '0, error_offset: '0};
        n = n + 3'd1;
      end
    end

    batch.count = n;
  end

  assign batch_valid = accept && (n != '0);

endmodule

@@ sv/rnbd_back.sv @@
module rnbd_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  rnbd_pkg::batch_t  q_data,
  output logic              q_pop,
  output rnbd_pkg::result_t result,
  output logic              empty,
  input  logic              pop
);
  import rnbd_pkg::*;

  logic       res_valid;
  logic [1:0] idx;
  logic       load;
  logic       is_last;
  entry_t     cur;

  assign empty   = !res_valid;
  assign load    = q_valid && (!res_valid || pop);
  assign is_last = (({1'b0, idx} + 3'd1) >= q_data.count);
  assign cur     = q_data.entry[idx];
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        res_valid <= 1'b1;
        idx       <= is_last ? 2'd0 : idx + 2'd1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.kind         <= cur.kind;
      result.byte_out     <= cur.byte_out;
      result.error_offset <= cur.error_offset;
      result.last         <= is_last;
    end
  end

endmodule

@@ sv/rnews_batch_deframer_unit.sv @@
// News batch deframer. Bytes of a batch file enter on the item channel
// (push/full, end_of_file marks the last byte); per article the block
// checks the "#! rnews <len>" header line, then passes the declared number
// of body bytes with CR-LF folded to LF, cut off at a NUL, then an article-end
// result. A clean file end adds a finished result; a framing fault gives a
// single corrupt result with the byte offset and the rest of the file is
// ignored. Each byte yields zero to four results, the last one flagged.
// Results leave on the result channel (empty/pop), oldest first.
// cfg_valid/cfg_ready/cfg_data write the maximum article length; write it
// only while no transaction is in flight.
// Throughput: one byte per cycle while results drain at one per cycle;
// a byte that yields several results holds the output for each of them, and
// the batch queue between classifier and serializer (QUEUE_DEPTH bytes'
// worth) absorbs the difference. The first result of a byte passes through
// the batch queue and then the output register before it reaches the
// result ports. When pop stays low, results back up into the queue
// and full rises once it holds QUEUE_DEPTH batches. Synchronous reset
// returns to the start of a file, sets the maximum length to all ones
// and drops pending results.
module rnews_batch_deframer_unit #(
  parameter int LENGTH_BITS = rnbd_pkg::LENGTH_BITS_DEFAULT,
  parameter int QUEUE_DEPTH = rnbd_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  rnbd_pkg::item_t   item,
  output logic              empty,
  input  logic              pop,
  output rnbd_pkg::result_t result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [31:0]       cfg_data
);
  import rnbd_pkg::*;

  logic   accept;
  logic   batch_valid;
  batch_t batch;
  logic   q_empty;
  logic   q_pop;
  batch_t q_data;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  rnbd_front #(
    .LENGTH_BITS(LENGTH_BITS)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .item        (item),
    .cfg_write   (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .batch_valid (batch_valid),
    .batch       (batch)
  );

  rnbd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (batch_valid),
    .wr_data (batch),
    .full    (full),
    .rd_en   (q_pop),
    .rd_data (q_data),
    .empty   (q_empty)
  );

  rnbd_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (!q_empty),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .result  (result),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
